// ===== rtl/core/bdlp_pkg.sv =====
// Shared types, constants and helpers for the button debouncer.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int OUT_LANES       = 4;
  localparam int MASK_W          = 4;
  localparam int CNT_W           = 6;
  localparam int QUIET_W         = 4;
  localparam int EV_W            = 3;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 6;

  localparam logic [CNT_W-1:0]   DEBOUNCE_RST = 6'd3;
  localparam logic [CNT_W-1:0]   LONG_RST     = 6'd32;
  localparam logic [CNT_W-1:0]   REPEAT_RST   = 6'd47;
  localparam logic [QUIET_W-1:0] QUIET_RST    = 4'd3;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WAIT   = 1'b1;

  typedef enum logic [1:0] {
    PH_UP    = 2'd0,
    PH_MAYBE = 2'd1,
    PH_DOWN  = 2'd2,
    PH_LONG  = 2'd3
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_QUIET    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]   debounce;
    logic [CNT_W-1:0]   long_cnt;
    logic [CNT_W-1:0]   repeat_cnt;
    logic [QUIET_W-1:0] quiet;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [MASK_W-1:0] mask;
  } item_t;

  // Per-lane command for one processed beat
  typedef struct packed {
    logic force_rel;
    logic sample;
    logic pressed;
  } lane_cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == {CNT_W{1'b1}}) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
    return r;
  endfunction

endpackage

// ===== rtl/core/bdlp_if.sv =====
// Valid/ready channel interfaces for samples in and events out.
`timescale 1ns / 1ps

interface bdlp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bdlp_pkg::MASK_W-1:0]  pressed_mask;

  modport source (output valid, output kind, output pressed_mask, input ready);
  modport sink   (input valid, input kind, input pressed_mask, output ready);
endinterface

interface bdlp_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdlp_pkg::EV_W-1:0]  event_first;
  logic [bdlp_pkg::EV_W-1:0]  event_second;
  logic [bdlp_pkg::EV_W-1:0]  event_third;
  logic [bdlp_pkg::EV_W-1:0]  event_fourth;
  logic                       waiting;

  modport source (output valid, output event_first, output event_second,
                  output event_third, output event_fourth, output waiting,
                  input ready);
  modport sink   (input valid, input event_first, input event_second,
                  input event_third, input event_fourth, input waiting,
                  output ready);
endinterface

// ===== rtl/core/bdlp_lane.sv =====
// One button: debounce, long press and repeat state machine with its counter.
`timescale 1ns / 1ps

module bdlp_lane (
  input  logic                clk,
  input  logic                rst,
  input  bdlp_pkg::cfg_t      cfg,
  input  bdlp_pkg::lane_cmd_t cmd,
  output bdlp_pkg::event_t    ev
);

  bdlp_pkg::phase_t                phase;
  bdlp_pkg::phase_t                phase_next;
  logic [bdlp_pkg::CNT_W-1:0]      count;
  logic [bdlp_pkg::CNT_W-1:0]      count_next;
  logic [bdlp_pkg::CNT_W-1:0]      inc;

  assign inc = bdlp_pkg::sat_inc(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bdlp_pkg::PH_UP;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  always_comb begin
    phase_next = phase;
    count_next = count;
    ev         = bdlp_pkg::EV_NONE;
    if (cmd.force_rel || (cmd.sample && !cmd.pressed)) begin
      if (phase == bdlp_pkg::PH_DOWN || phase == bdlp_pkg::PH_LONG) begin
        ev = bdlp_pkg::EV_RELEASE;
      end
      phase_next = bdlp_pkg::PH_UP;
      count_next = '0;
    end else if (cmd.sample) begin
      unique case (phase)
        bdlp_pkg::PH_UP: begin
          count_next = {{(bdlp_pkg::CNT_W-1){1'b0}}, 1'b1};
          if ({{(bdlp_pkg::CNT_W-1){1'b0}}, 1'b1} >= cfg.debounce) begin
            phase_next = bdlp_pkg::PH_DOWN;
            ev         = bdlp_pkg::EV_PRESS;
          end else begin
            phase_next = bdlp_pkg::PH_MAYBE;
          end
        end
        bdlp_pkg::PH_MAYBE: begin
          count_next = inc;
          if (inc >= cfg.debounce) begin
            phase_next = bdlp_pkg::PH_DOWN;
            ev         = bdlp_pkg::EV_PRESS;
          end
        end
        bdlp_pkg::PH_DOWN: begin
          count_next = inc;
          if (inc >= cfg.long_cnt) begin
            phase_next = bdlp_pkg::PH_LONG;
            ev         = bdlp_pkg::EV_LONG;
          end
        end
        bdlp_pkg::PH_LONG: begin
          // repeat reloads to the long threshold
          if (inc >= cfg.repeat_cnt) begin
            count_next = cfg.long_cnt;
            ev         = bdlp_pkg::EV_REPEAT;
          end else begin
            count_next = inc;
          end
        end
      endcase
    end
  end

  a_up_count_zero: assert property (@(posedge clk) disable iff (rst)
    phase == bdlp_pkg::PH_UP |-> count == '0)
    else $error("button up with nonzero count");

  a_force_release: assert property (@(posedge clk) disable iff (rst)
    cmd.force_rel |=> phase == bdlp_pkg::PH_UP)
    else $error("wait request did not release button");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.force_rel && !cmd.sample |=> $stable(phase) && $stable(count))
    else $error("button state moved without a sample");

endmodule

// ===== rtl/core/bdlp_wait_ctrl.sv =====
// Wait mode tracking: entered on a wait request, left after enough quiet samples.
`timescale 1ns / 1ps

module bdlp_wait_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  bdlp_pkg::item_t               item,
  input  logic [bdlp_pkg::QUIET_W-1:0]  quiet,
  output logic                          wait_mode,
  output logic                          wait_next
);

  logic [bdlp_pkg::QUIET_W-1:0] quiet_left;
  logic [bdlp_pkg::QUIET_W-1:0] quiet_left_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_mode  <= 1'b0;
      quiet_left <= '0;
    end else begin
      wait_mode  <= wait_next;
      quiet_left <= quiet_left_next;
    end
  end

  always_comb begin
    wait_next       = wait_mode;
    quiet_left_next = quiet_left;
    if (step) begin
      if (item.kind == bdlp_pkg::KIND_WAIT) begin
        wait_next       = 1'b1;
        quiet_left_next = quiet;
      end else if (wait_mode) begin
        if (item.mask == '0) begin
          // zero or one left ends wait at once
          if (quiet_left <= {{(bdlp_pkg::QUIET_W-1){1'b0}}, 1'b1}) begin
            quiet_left_next = '0;
            wait_next       = 1'b0;
          end else begin
            quiet_left_next = quiet_left - {{(bdlp_pkg::QUIET_W-1){1'b0}}, 1'b1};
          end
        end else begin
          quiet_left_next = quiet;
        end
      end
    end
  end

endmodule

// ===== rtl/core/button_debounce_long_press_repeat.sv =====
// Top level: debouncer with long press and auto-repeat for up to four buttons.
//
// sample_in carries one beat per periodic sample: kind 0 is a button sample
// with pressed_mask (bit i = button i pressed), kind 1 is a wait request that
// releases every held button and mutes samples until quiet_count all-zero
// samples have arrived. event_out returns exactly one beat per input beat:
// an event code per button (none, press, long, repeat, release) and the wait
// flag after that step.
// A beat passes an input register, then the lane and wait logic that write the
// output register. One beat is taken per cycle while event_out does not stall;
// the output register and the input register let a new beat in while a result
// waits. When event_out stalls, the input register fills and then sample_in.ready
// drops until the output register is taken. Reset puts all buttons up with zero
// counts, leaves wait mode, loads default thresholds (debounce 3, long 32,
// repeat 47, quiet 3). The user must write cfg_we / cfg_index / cfg_data only
// while no beat is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module button_debounce_long_press_repeat #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bdlp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_data,
  bdlp_in_if.sink                           sample_in,
  bdlp_out_if.source                        event_out
);

  localparam int LANES = (NUM_BUTTONS < bdlp_pkg::OUT_LANES) ?
                         NUM_BUTTONS : bdlp_pkg::OUT_LANES;

  bdlp_pkg::cfg_t       cfg;
  bdlp_pkg::item_t      s1_item;
  logic                 s1_valid;
  logic                 s1_fire;
  logic                 in_fire;
  logic                 out_valid;
  logic                 out_free;
  logic                 wait_mode;
  logic                 wait_next;
  logic                 force_rel;
  logic                 sample_en;
  bdlp_pkg::event_t     ev [bdlp_pkg::OUT_LANES];
  bdlp_pkg::event_t     ev_q [bdlp_pkg::OUT_LANES];
  logic                 waiting_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce   <= bdlp_pkg::DEBOUNCE_RST;
      cfg.long_cnt   <= bdlp_pkg::LONG_RST;
      cfg.repeat_cnt <= bdlp_pkg::REPEAT_RST;
      cfg.quiet      <= bdlp_pkg::QUIET_RST;
    end else if (cfg_we) begin
      unique case (bdlp_pkg::cfg_reg_t'(cfg_index))
        bdlp_pkg::REG_DEBOUNCE: cfg.debounce   <= cfg_data;
        bdlp_pkg::REG_LONG:     cfg.long_cnt   <= cfg_data;
        bdlp_pkg::REG_REPEAT:   cfg.repeat_cnt <= cfg_data;
        bdlp_pkg::REG_QUIET:    cfg.quiet      <= cfg_data[bdlp_pkg::QUIET_W-1:0];
      endcase
    end
  end

  assign out_free        = !out_valid || event_out.ready;
  assign s1_fire         = s1_valid && out_free;
  assign sample_in.ready = !s1_valid || out_free;
  assign in_fire         = sample_in.valid && sample_in.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.kind <= sample_in.kind;
      s1_item.mask <= sample_in.pressed_mask;
    end
  end

  bdlp_wait_ctrl u_wait (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .item      (s1_item),
    .quiet     (cfg.quiet),
    .wait_mode (wait_mode),
    .wait_next (wait_next)
  );

  assign force_rel = s1_fire && (s1_item.kind == bdlp_pkg::KIND_WAIT) && !wait_mode;
  assign sample_en = s1_fire && (s1_item.kind == bdlp_pkg::KIND_SAMPLE) && !wait_mode;

  for (genvar b = 0; b < bdlp_pkg::OUT_LANES; b++) begin : g_lane
    if (b < LANES) begin : g_on
      bdlp_pkg::lane_cmd_t cmd;
      assign cmd.force_rel = force_rel;
      assign cmd.sample    = sample_en;
      assign cmd.pressed   = s1_item.mask[b];
      bdlp_lane u_lane (
        .clk (clk),
        .rst (rst),
        .cfg (cfg),
        .cmd (cmd),
        .ev  (ev[b])
      );
    end else begin : g_off
      assign ev[b] = bdlp_pkg::EV_NONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      ev_q      <= ev;
      waiting_q <= wait_next;
    end
  end

  assign event_out.valid        = out_valid;
  assign event_out.event_first  = ev_q[0];
  assign event_out.event_second = ev_q[1];
  assign event_out.event_third  = ev_q[2];
  assign event_out.event_fourth = ev_q[3];
  assign event_out.waiting      = waiting_q;

endmodule
